>>> rtl/assert_macros.svh
// Assertion macros used by the checker file of the block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define ASSERT_SYNC(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/ffba_pkg.sv
// Shared types and constants of the first-fit block allocator.
`default_nettype none

package ffba_pkg;

    // Pool and table geometry
    localparam int POOL_BYTES = 4096;
    localparam int MAX_BLOCKS = 64;
    localparam int OFF_W      = 12;
    localparam int SIZE_W     = 13;
    localparam int IDX_W      = $clog2(MAX_BLOCKS);
    localparam int CNT_W      = $clog2(MAX_BLOCKS + 1);

    localparam logic [SIZE_W-1:0] POOL_SIZE  = SIZE_W'(POOL_BYTES);
    localparam logic [CNT_W-1:0]  TABLE_FULL = CNT_W'(MAX_BLOCKS);

    // Request kinds
    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } op_t;

    // Result codes
    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_NO_FIT     = 2'd1,
        ST_NOT_ALLOC  = 2'd2,
        ST_TABLE_FULL = 2'd3
    } status_t;

    // One table entry: start offset and size of an allocated block
    typedef struct packed {
        logic [OFF_W-1:0]  start;
        logic [SIZE_W-1:0] size;
    } entry_t;

    typedef struct packed {
        op_t               opcode;
        logic [SIZE_W-1:0] alloc_size;
        logic [OFF_W-1:0]  block_offset;
    } req_t;

    typedef struct packed {
        status_t          status;
        logic [OFF_W-1:0] granted_offset;
    } rsp_t;

endpackage

`default_nettype wire

>>> rtl/first_fit_block_allocator_top.sv
// Top level of the first-fit block allocator: stream ports and output register.
//
// Use: the slave channel takes one request word per handshake. s_tuser is the
// opcode (0 allocate, 1 free); s_tdata carries alloc_size and block_offset.
// Every request gives exactly one result word on the master channel: m_tuser
// is the status (0 ok, 1 no gap fits, 2 offset not allocated, 3 table full)
// and m_tdata the granted offset, zero unless an allocate succeeded.
// One request is worked on at a time. A request walks the block table in its
// memory one entry per cycle through the single read port, so the wait for a
// result grows with the number of blocks in use (up to 64); a full table or a
// zero size skips the walk. Inserting or removing an entry rides along in the
// same walk.
// The result sits in an output register; the next request is accepted while
// it waits. If the receiver stalls, the following result waits inside the
// walker and no further request is taken until it moves on.
// Reset (aresetn low, synchronous) empties the table; the memory contents
// need no clearing, since only entries below the block count are read.
`default_nettype none

module first_fit_block_allocator_top (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // [12:0] alloc_size, [24:13] block_offset, zero above
    input  wire logic        s_tuser,   // [0] opcode
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // [11:0] granted_offset, zero above
    output logic [1:0]       m_tuser    // [1:0] status
);

    ffba_pkg::req_t  req;
    ffba_pkg::rsp_t  rsp;
    logic            rsp_valid;
    logic            rsp_ready;

    logic            m_tvalid_reg;
    logic [15:0]     m_tdata_reg;
    logic [1:0]      m_tuser_reg;

    // Unpack the request word
    assign req.opcode       = ffba_pkg::op_t'(s_tuser);
    assign req.alloc_size   = s_tdata[12:0];
    assign req.block_offset = s_tdata[24:13];

    ffba_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req_valid (s_tvalid),
        .req_ready (s_tready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    // Output register: load when empty or being drained
    assign rsp_ready = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            if (rsp_valid && rsp_ready) begin
                m_tvalid_reg <= 1'b1;
                m_tdata_reg  <= {4'b0, rsp.granted_offset};
                m_tuser_reg  <= rsp.status;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

`default_nettype wire

>>> rtl/ffba_core.sv
// Table walker of the allocator: block table memory and request sequencer.
`default_nettype none

module ffba_core (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          req_valid,
    output logic               req_ready,
    input  wire ffba_pkg::req_t req,
    output logic               rsp_valid,
    input  wire logic          rsp_ready,
    output ffba_pkg::rsp_t     rsp
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_FIND,
        S_CLOSE,
        S_DONE
    } state_t;

    state_t                          state_reg, state_next;
    logic [ffba_pkg::CNT_W-1:0]      count_reg, count_next;
    logic [ffba_pkg::CNT_W-1:0]      idx_reg, idx_next;
    logic [ffba_pkg::SIZE_W-1:0]     size_reg, size_next;
    logic [ffba_pkg::OFF_W-1:0]      off_reg, off_next;
    logic [ffba_pkg::SIZE_W-1:0]     cand_reg, cand_next;
    ffba_pkg::entry_t                carry_reg, carry_next;
    ffba_pkg::status_t               status_reg, status_next;
    logic [ffba_pkg::OFF_W-1:0]      granted_reg, granted_next;

    // Block table: one write port, one registered read port
    ffba_pkg::entry_t                mem [ffba_pkg::MAX_BLOCKS];
    ffba_pkg::entry_t                rd_data_reg;
    logic [ffba_pkg::IDX_W-1:0]      rd_addr;
    logic                            wr_en;
    logic [ffba_pkg::IDX_W-1:0]      wr_addr;
    ffba_pkg::entry_t                wr_data;

    logic                            in_range;
    logic [ffba_pkg::SIZE_W-1:0]     entry_start;
    logic [ffba_pkg::SIZE_W-1:0]     gap;
    logic                            gap_fits;
    logic                            tail_fits;
    logic [ffba_pkg::CNT_W-1:0]      idx_prev;

    // Entry under test and the gap in front of it
    assign in_range    = (idx_reg < count_reg);
    assign entry_start = ffba_pkg::SIZE_W'(rd_data_reg.start);
    assign gap         = entry_start - cand_reg;
    assign gap_fits    = (entry_start >= cand_reg) && (gap >= size_reg);
    assign tail_fits   = (cand_reg <= ffba_pkg::POOL_SIZE) &&
                         ((ffba_pkg::POOL_SIZE - cand_reg) >= size_reg);
    assign idx_prev    = idx_reg - ffba_pkg::CNT_W'(1);

    // Always fetch the entry that the next cycle looks at
    assign rd_addr = idx_next[ffba_pkg::IDX_W-1:0];

    // Sequencer next state
    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        idx_next     = idx_reg;
        size_next    = size_reg;
        off_next     = off_reg;
        cand_next    = cand_reg;
        carry_next   = carry_reg;
        status_next  = status_reg;
        granted_next = granted_reg;
        wr_en        = 1'b0;
        wr_addr      = idx_reg[ffba_pkg::IDX_W-1:0];
        wr_data      = carry_reg;

        case (state_reg)
            S_IDLE: begin
                if (req_valid) begin
                    size_next    = req.alloc_size;
                    off_next     = req.block_offset;
                    cand_next    = '0;
                    idx_next     = '0;
                    granted_next = '0;
                    status_next  = ffba_pkg::ST_OK;
                    if (req.opcode == ffba_pkg::OP_FREE) begin
                        state_next = S_FIND;
                    end else if (count_reg == ffba_pkg::TABLE_FULL) begin
                        status_next = ffba_pkg::ST_TABLE_FULL;
                        state_next  = S_DONE;
                    end else if (req.alloc_size == '0) begin
                        status_next = ffba_pkg::ST_NO_FIT;
                        state_next  = S_DONE;
                    end else begin
                        state_next = S_SCAN;
                    end
                end
            end

            // Walk the gaps in address order
            S_SCAN: begin
                if (in_range) begin
                    idx_next = idx_reg + ffba_pkg::CNT_W'(1);
                    if (gap_fits) begin
                        wr_en        = 1'b1;
                        wr_data      = '{start: cand_reg[ffba_pkg::OFF_W-1:0], size: size_reg};
                        carry_next   = rd_data_reg;
                        granted_next = cand_reg[ffba_pkg::OFF_W-1:0];
                        state_next   = S_SHIFT;
                    end else begin
                        cand_next = entry_start + rd_data_reg.size;
                    end
                end else if (tail_fits) begin
                    wr_en        = 1'b1;
                    wr_data      = '{start: cand_reg[ffba_pkg::OFF_W-1:0], size: size_reg};
                    count_next   = count_reg + ffba_pkg::CNT_W'(1);
                    granted_next = cand_reg[ffba_pkg::OFF_W-1:0];
                    state_next   = S_DONE;
                end else begin
                    status_next = ffba_pkg::ST_NO_FIT;
                    state_next  = S_DONE;
                end
            end

            // Ripple the displaced entries one place up
            S_SHIFT: begin
                wr_en = 1'b1;
                if (in_range) begin
                    carry_next = rd_data_reg;
                    idx_next   = idx_reg + ffba_pkg::CNT_W'(1);
                end else begin
                    count_next = count_reg + ffba_pkg::CNT_W'(1);
                    state_next = S_DONE;
                end
            end

            // Look for the block that starts at the given offset
            S_FIND: begin
                if (in_range) begin
                    idx_next = idx_reg + ffba_pkg::CNT_W'(1);
                    if (rd_data_reg.start == off_reg) begin
                        state_next = S_CLOSE;
                    end
                end else begin
                    status_next = ffba_pkg::ST_NOT_ALLOC;
                    state_next  = S_DONE;
                end
            end

            // Close the hole: move each later entry one place down
            S_CLOSE: begin
                if (in_range) begin
                    wr_en    = 1'b1;
                    wr_addr  = idx_prev[ffba_pkg::IDX_W-1:0];
                    wr_data  = rd_data_reg;
                    idx_next = idx_reg + ffba_pkg::CNT_W'(1);
                end else begin
                    count_next = count_reg - ffba_pkg::CNT_W'(1);
                    state_next = S_DONE;
                end
            end

            // Hold the result until the output stage takes it
            S_DONE: begin
                if (rsp_ready) begin
                    state_next = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and result registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            idx_reg     <= idx_next;
            size_reg    <= size_next;
            off_reg     <= off_next;
            cand_reg    <= cand_next;
            carry_reg   <= carry_next;
            status_reg  <= status_next;
            granted_reg <= granted_next;
        end
    end

    // Table memory
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign req_ready          = (state_reg == S_IDLE);
    assign rsp_valid          = (state_reg == S_DONE);
    assign rsp.status         = status_reg;
    assign rsp.granted_offset = granted_reg;

endmodule

`default_nettype wire

>>> rtl/ffba_checker.sv
// Port-level checks of the allocator and their binding to the top level.
`default_nettype none
`include "assert_macros.svh"

module ffba_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [15:0] m_tdata,
    input wire logic [1:0]  m_tuser
);

    // A stalled result word holds
    `ASSERT_SYNC(a_hold_stall, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result word changed while stalled")

    // A failed request grants no offset
    `ASSERT_SYNC(a_zero_on_fail, aclk, aresetn, m_tvalid && (m_tuser != ffba_pkg::ST_OK) |-> m_tdata == 16'd0, "granted offset not zero on a failed request")

    // Only one request is in work at a time
    `ASSERT_SYNC(a_one_in_work, aclk, aresetn, s_tvalid && s_tready |=> !s_tready, "request taken while another is in work")

    // Reset leaves no result pending
    `ASSERT_ALWAYS(a_reset_empty, aclk, !aresetn |=> !m_tvalid, "result valid after reset")

endmodule

bind first_fit_block_allocator_top ffba_checker u_ffba_checker (.*);

`default_nettype wire
